>>> hdl/lsaf_pkg.sv
// Package: constants, sensor offsets and arctangent table for the line sensor angle filter.
`timescale 1ns / 1ps
package lsaf_pkg;

  localparam int MedianDepthDefault = 5;
  localparam int SensorCount = 8;
  localparam int CordicSteps = 16;
  localparam int AngleMaxQ16 = 4608 * 256;
  localparam int BaseDistance = 130;

  localparam logic [7:0] SampleCountReset = 8'd10;
  localparam logic [8:0] AlphaReset = 9'd90;
  localparam logic [12:0] DeadBandReset = 13'd691;

  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] REG_ALPHA = 2'd1;
  localparam logic [1:0] REG_DEAD_BAND = 2'd2;

  function automatic logic signed [6:0] sensor_offset(input logic [2:0] idx);
    logic signed [6:0] v;
    case (idx)
      3'd0: v = -7'sd42;
      3'd1: v = -7'sd30;
      3'd2: v = -7'sd18;
      3'd3: v = -7'sd6;
      3'd4: v = 7'sd6;
      3'd5: v = 7'sd18;
      3'd6: v = 7'sd30;
      3'd7: v = 7'sd42;
      default: v = 7'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [21:0] atan_step(input logic [3:0] idx);
    logic [21:0] v;
    case (idx)
      4'd0: v = 22'd2949120;
      4'd1: v = 22'd1740967;
      4'd2: v = 22'd919879;
      4'd3: v = 22'd466945;
      4'd4: v = 22'd234379;
      4'd5: v = 22'd117304;
      4'd6: v = 22'd58666;
      4'd7: v = 22'd29335;
      4'd8: v = 22'd14668;
      4'd9: v = 22'd7334;
      4'd10: v = 22'd3667;
      4'd11: v = 22'd1833;
      4'd12: v = 22'd917;
      4'd13: v = 22'd458;
      4'd14: v = 22'd229;
      4'd15: v = 22'd115;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/line_sensor_angle_filter.sv
// Line sensor angle filter: vote batches, CORDIC arctangent, median, EWMA and deadband.
`timescale 1ns / 1ps
// Frames are taken one per cycle while a batch fills. The frame that ends a batch
// starts a sequencer that runs hit summing over one shared multiply-add, 16 CORDIC
// steps through one shared shifter and adder pair, median selection over up to
// MEDIAN_DEPTH candidates once the window is full, and setup, rounding, window
// update, EWMA, deadband and output (the CORDIC steps and rounding are skipped when
// the line is lost or centered, and the window update as well when it is lost),
// during which in_stall is high. The result sits in an output register, so the next
// batch may fill while it waits to be taken; a batch that ends while it still waits
// holds in_stall high until the register is free.
module line_sensor_angle_filter #(
  parameter int MEDIAN_DEPTH = lsaf_pkg::MedianDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         sensor_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [13:0] bias_angle,
  output logic [7:0]         confirmed_mask,
  output logic [3:0]         line_count,
  output logic               line_lost
);
  import lsaf_pkg::*;

  localparam int PW = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
  localparam int FW = $clog2(MEDIAN_DEPTH + 1);
  localparam int MidRank = MEDIAN_DEPTH / 2;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_SUM    = 12'b000000000010,
    ST_PREP   = 12'b000000000100,
    ST_CORDIC = 12'b000000001000,
    ST_ROUND  = 12'b000000010000,
    ST_WRITE  = 12'b000000100000,
    ST_PICK   = 12'b000001000000,
    ST_MED    = 12'b000010000000,
    ST_MUL    = 12'b000100000000,
    ST_ADD    = 12'b001000000000,
    ST_BAND   = 12'b010000000000,
    ST_OUT    = 12'b100000000000
  } state_t;

  state_t state;

  logic [7:0]  sample_count;
  logic [8:0]  smoothing_alpha;
  logic [12:0] dead_band;

  logic [7:0]  hit_counts [SensorCount];
  logic [7:0]  frame_counter;
  logic signed [13:0] held_angle;
  logic signed [13:0] median_window [MEDIAN_DEPTH];
  logic [PW-1:0] window_pointer;
  logic [FW-1:0] window_fill;
  logic signed [22:0] smoothed_state;

  logic [3:0]  step;
  logic signed [17:0] pos_sum;
  logic [10:0] hit_sum;
  logic [7:0]  mask;
  logic [3:0]  count;
  logic signed [35:0] cx;
  logic signed [35:0] cy;
  logic signed [24:0] cz;
  logic        neg;
  logic signed [13:0] raw;
  logic signed [13:0] filt;
  logic signed [33:0] prod;

  logic [7:0]  n_eff;
  logic [7:0]  frame_next;
  logic        in_take;
  logic        out_take;
  logic        cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall = (state != ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign n_eff = (sample_count == 8'd0) ? 8'd1 : sample_count;
  assign frame_next = (frame_counter == 8'd255) ? frame_counter : frame_counter + 8'd1;

  always_comb begin
    case (paddr[3:2])
      REG_SAMPLE_COUNT: prdata = {24'd0, sample_count};
      REG_ALPHA: prdata = {23'd0, smoothing_alpha};
      REG_DEAD_BAND: prdata = {19'd0, dead_band};
      default: prdata = 32'd0;
    endcase
  end

  // shared datapath pieces
  logic [7:0] cur_hit;
  logic signed [15:0] hit_term;
  logic signed [35:0] sx;
  logic signed [35:0] sy;
  logic [17:0] pos_mag;
  logic signed [24:0] z_clamped;
  logic [12:0] r_mag;
  logic [PW-1:0] cand_idx;
  logic signed [13:0] cand;
  logic [MEDIAN_DEPTH-1:0] lt_vec;
  logic [MEDIAN_DEPTH-1:0] le_vec;
  logic [FW-1:0] lt_cnt;
  logic [FW-1:0] le_cnt;
  logic signed [23:0] diff;
  logic [8:0]  alpha_eff;
  logic signed [26:0] ewma_sum;
  logic signed [23:0] band;
  logic signed [23:0] round_out;

  assign cur_hit = hit_counts[step[2:0]];
  assign hit_term = $signed({1'b0, cur_hit}) * sensor_offset(step[2:0]);
  assign sx = cx >>> step;
  assign sy = cy >>> step;
  assign pos_mag = pos_sum[17] ? 18'(-pos_sum) : 18'(pos_sum);
  assign cand_idx = step[PW-1:0];
  assign cand = median_window[cand_idx];

  always_comb begin
    for (int j = 0; j < MEDIAN_DEPTH; j++) begin
      lt_vec[j] = median_window[j] < cand;
      le_vec[j] = median_window[j] <= cand;
    end
  end
  assign lt_cnt = FW'($countones(lt_vec));
  assign le_cnt = FW'($countones(le_vec));

  always_comb begin
    if (cz < 0) begin
      z_clamped = 25'sd0;
    end else if (cz > 25'(AngleMaxQ16)) begin
      z_clamped = 25'(AngleMaxQ16);
    end else begin
      z_clamped = cz;
    end
  end
  assign r_mag = 13'((z_clamped + 25'sd128) >>> 8);

  assign alpha_eff = (smoothing_alpha > 9'd256) ? 9'd256 : smoothing_alpha;
  assign diff = 24'(filt) * 24'sd256 - 24'(smoothed_state);
  assign ewma_sum = 27'(smoothed_state) + 27'((prod + 34'sd128) >>> 8);
  assign band = $signed({3'b000, dead_band, 8'd0});
  assign round_out = (24'(smoothed_state) + 24'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sample_count <= SampleCountReset;
      smoothing_alpha <= AlphaReset;
      dead_band <= DeadBandReset;
      for (int i = 0; i < SensorCount; i++) hit_counts[i] <= 8'd0;
      frame_counter <= 8'd0;
      held_angle <= 14'sd0;
      for (int i = 0; i < MEDIAN_DEPTH; i++) median_window[i] <= 14'sd0;
      window_pointer <= '0;
      window_fill <= '0;
      smoothed_state <= 23'sd0;
      out_valid <= 1'b0;
      step <= 4'd0;
    end else begin
      if (cfg_write) begin
        case (paddr[3:2])
          REG_SAMPLE_COUNT: sample_count <= pwdata[7:0];
          REG_ALPHA: smoothing_alpha <= pwdata[8:0];
          REG_DEAD_BAND: dead_band <= pwdata[12:0];
          default: ;
        endcase
      end
      if (state == ST_OUT && (!out_valid || out_take)) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_take) begin
            for (int i = 0; i < SensorCount; i++) begin
              if (!sensor_bits[i] && hit_counts[i] != 8'd255) begin
                hit_counts[i] <= hit_counts[i] + 8'd1;
              end
            end
            frame_counter <= frame_next;
            if (frame_next >= n_eff) begin
              state <= ST_SUM;
              step <= 4'd0;
            end
          end
        end
        ST_SUM: begin
          if (step == 4'd0) begin
            pos_sum <= 18'(hit_term);
            hit_sum <= 11'(cur_hit);
            mask <= {7'd0, cur_hit > (n_eff >> 1)};
            count <= {3'd0, cur_hit > (n_eff >> 1)};
          end else begin
            pos_sum <= pos_sum + 18'(hit_term);
            hit_sum <= hit_sum + 11'(cur_hit);
            mask[step[2:0]] <= cur_hit > (n_eff >> 1);
            count <= count + {3'd0, cur_hit > (n_eff >> 1)};
          end
          if (step == 4'd7) begin
            state <= ST_PREP;
            step <= 4'd0;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_PREP: begin
          neg <= pos_sum[17];
          step <= 4'd0;
          if (count == 4'd0) begin
            raw <= held_angle;
            state <= ST_PICK;
          end else if (pos_sum == 18'sd0) begin
            raw <= 14'sd0;
            state <= ST_WRITE;
          end else begin
            cx <= $signed({17'd0, 19'(hit_sum * 19'(BaseDistance))}) <<< 14;
            cy <= $signed({18'd0, pos_mag}) <<< 14;
            cz <= 25'sd0;
            state <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (cy > 0) begin
            cx <= cx + sy;
            cy <= cy - sx;
            cz <= cz + $signed({3'b000, atan_step(step)});
          end else begin
            cx <= cx - sy;
            cy <= cy + sx;
            cz <= cz - $signed({3'b000, atan_step(step)});
          end
          step <= step + 4'd1;
          if (step == 4'(CordicSteps - 1)) state <= ST_ROUND;
        end
        ST_ROUND: begin
          raw <= neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          held_angle <= raw;
          median_window[window_pointer] <= raw;
          window_pointer <= (window_pointer == PW'(MEDIAN_DEPTH - 1)) ? '0
                            : window_pointer + PW'(1);
          if (window_fill < FW'(MEDIAN_DEPTH)) window_fill <= window_fill + FW'(1);
          state <= ST_PICK;
        end
        ST_PICK: begin
          step <= 4'd0;
          if (window_fill >= FW'(MEDIAN_DEPTH)) begin
            state <= ST_MED;
          end else begin
            filt <= raw;
            state <= ST_MUL;
          end
        end
        ST_MED: begin
          if (lt_cnt <= FW'(MidRank) && FW'(MidRank) < le_cnt) begin
            filt <= cand;
            state <= ST_MUL;
          end
          step <= step + 4'd1;
        end
        ST_MUL: begin
          prod <= 34'(diff) * $signed({1'b0, alpha_eff});
          state <= ST_ADD;
        end
        ST_ADD: begin
          smoothed_state <= ewma_sum[22:0];
          state <= ST_BAND;
        end
        ST_BAND: begin
          if (24'(smoothed_state) > -band && 24'(smoothed_state) < band) begin
            smoothed_state <= 23'sd0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_take) begin
            for (int i = 0; i < SensorCount; i++) hit_counts[i] <= 8'd0;
            frame_counter <= 8'd0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_take)) begin
      bias_angle <= round_out[13:0];
      confirmed_mask <= mask;
      line_count <= count;
      line_lost <= (count == 4'd0);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill <= FW'(MEDIAN_DEPTH))
    else $error("window fill beyond depth");

  a_batch_start: assert property (@(posedge clk) disable iff (rst)
    (in_take && frame_next >= n_eff) |=> state == ST_SUM)
    else $error("batch end did not start the sequencer");

  a_lost_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_lost == (line_count == 4'd0)))
    else $error("line_lost disagrees with line_count");

  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(confirmed_mask) == line_count))
    else $error("confirmed mask and count disagree");

endmodule
